/* rtl/jse_pkg.sv */
// ----------------------------------------------------------------------------
// jse_pkg: shared types and helpers for the JSON string escaper
// Job format passed from the front end to the back end, character codes,
// and the escape classification and hex digit functions.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Width of one UTF-16 code unit
  localparam int unsigned UnitW = 16;

  // Operations per job: opening quote, held lead, current unit or closing quote
  localparam int unsigned NumOps = 3;
  localparam int unsigned IdxW   = $clog2(NumOps);

  // Job queue depth between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Sub-step counter: a hex escape has six units
  localparam int unsigned SubW = 3;

  // Character codes
  localparam logic [UnitW-1:0] ChQuote  = 16'h0022;
  localparam logic [UnitW-1:0] ChBslash = 16'h005c;
  localparam logic [UnitW-1:0] ChU      = 16'h0075;
  localparam logic [UnitW-1:0] ChB      = 16'h0062;
  localparam logic [UnitW-1:0] ChT      = 16'h0074;
  localparam logic [UnitW-1:0] ChN      = 16'h006e;
  localparam logic [UnitW-1:0] ChF      = 16'h0066;
  localparam logic [UnitW-1:0] ChR      = 16'h0072;
  localparam logic [UnitW-1:0] Ch0      = 16'h0030;
  localparam logic [UnitW-1:0] ChA      = 16'h0061;

  // Control codes with short escapes
  localparam logic [UnitW-1:0] CodeBs = 16'h0008;
  localparam logic [UnitW-1:0] CodeHt = 16'h0009;
  localparam logic [UnitW-1:0] CodeLf = 16'h000a;
  localparam logic [UnitW-1:0] CodeFf = 16'h000c;
  localparam logic [UnitW-1:0] CodeCr = 16'h000d;

  localparam logic [UnitW-1:0] CtrlLimit = 16'h0020;
  localparam logic [UnitW-1:0] SurrLo    = 16'hd800;
  localparam logic [UnitW-1:0] SurrHi    = 16'hdfff;

  // Surrogate class from the top six bits
  localparam logic [5:0] LeadTag  = 6'b110110;
  localparam logic [5:0] TrailTag = 6'b110111;

  // Kind of one output operation
  typedef enum logic [1:0] {
    OP_NONE,   // nothing
    OP_PLAIN,  // value as is
    OP_ESC2,   // backslash, then value
    OP_HEX     // backslash, u, four hex digits of value
  } op_kind_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [UnitW-1:0] value;
  } op_t;

  typedef struct packed {
    op_t [NumOps-1:0] ops;
  } job_t;

  // Front end state seen at the top level
  typedef struct packed {
    logic string_open;
    logic lead_pending;
  } front_status_t;

  localparam op_t OpNone = '{kind: OP_NONE, value: '0};

  // Number of units an operation emits
  function automatic logic [SubW-1:0] op_len(op_kind_e kind);
    logic [SubW-1:0] len;
    unique case (kind)
      OP_PLAIN: len = SubW'(1);
      OP_ESC2:  len = SubW'(2);
      OP_HEX:   len = SubW'(6);
      default:  len = '0;
    endcase
    return len;
  endfunction

  // Lower-case hex digit
  function automatic logic [UnitW-1:0] hex_digit(logic [3:0] nib);
    logic [UnitW-1:0] ch;
    if (nib < 4'd10) ch = Ch0 + UnitW'(nib);
    else             ch = ChA + UnitW'(nib) - UnitW'(10);
    return ch;
  endfunction

  // Escape a unit that is not part of a valid surrogate pair
  function automatic op_t classify(logic [UnitW-1:0] u);
    op_t op;
    op.value = u;
    unique case (u)
      CodeBs:   begin op.kind = OP_ESC2; op.value = ChB; end
      CodeHt:   begin op.kind = OP_ESC2; op.value = ChT; end
      CodeLf:   begin op.kind = OP_ESC2; op.value = ChN; end
      CodeFf:   begin op.kind = OP_ESC2; op.value = ChF; end
      CodeCr:   begin op.kind = OP_ESC2; op.value = ChR; end
      ChQuote:  begin op.kind = OP_ESC2; op.value = ChQuote; end
      ChBslash: begin op.kind = OP_ESC2; op.value = ChBslash; end
      default: begin
        if (u < CtrlLimit || (u >= SurrLo && u <= SurrHi)) op.kind = OP_HEX;
        else                                                op.kind = OP_PLAIN;
      end
    endcase
    return op;
  endfunction

  // First non-empty operation at or after start; top bit flags a hit
  function automatic logic [IdxW:0] find_op(job_t j, logic [IdxW:0] start);
    logic            found;
    logic [IdxW-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = NumOps - 1; i >= 0; i--) begin
      if (i >= int'(start) && j.ops[i].kind != OP_NONE) begin
        found = 1'b1;
        idx   = IdxW'(i);
      end
    end
    return {found, idx};
  endfunction

endpackage

/* rtl/jse_front.sv */
// ----------------------------------------------------------------------------
// jse_front: input side of the JSON string escaper
// Accepts items, tracks open string and held lead surrogate, and turns
// each item into a job of up to three output operations.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [jse_pkg::UnitW-1:0] in_unit_i,
  input  logic                   in_end_i,
  output logic                   push_o,
  input  logic                   push_ready_i,
  output jse_pkg::job_t          job_o,
  output jse_pkg::front_status_t status_o
);
  import jse_pkg::*;

  logic             open_q, open_d;
  logic             pend_q, pend_d;
  logic [UnitW-1:0] held_q, held_d;

  logic accept;
  logic is_lead, is_trail;
  logic any_op;
  job_t job;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign is_lead    = in_unit_i[UnitW-1 -: 6] == LeadTag;
  assign is_trail   = in_unit_i[UnitW-1 -: 6] == TrailTag;

  // Build the job and next state
  always_comb begin
    job.ops[0] = open_q ? OpNone : '{kind: OP_PLAIN, value: ChQuote};
    job.ops[1] = OpNone;
    job.ops[2] = OpNone;
    open_d     = open_q;
    pend_d     = pend_q;
    held_d     = held_q;
    if (in_end_i) begin
      if (pend_q) job.ops[1] = '{kind: OP_HEX, value: held_q};
      job.ops[2] = '{kind: OP_PLAIN, value: ChQuote};
      open_d     = 1'b0;
      pend_d     = 1'b0;
      held_d     = '0;
    end else if (pend_q && is_trail) begin
      // valid pair passes unchanged
      job.ops[1] = '{kind: OP_PLAIN, value: held_q};
      job.ops[2] = '{kind: OP_PLAIN, value: in_unit_i};
      open_d     = 1'b1;
      pend_d     = 1'b0;
    end else begin
      if (pend_q) job.ops[1] = '{kind: OP_HEX, value: held_q};
      open_d = 1'b1;
      if (is_lead) begin
        pend_d = 1'b1;
        held_d = in_unit_i;
      end else begin
        job.ops[2] = classify(in_unit_i);
        pend_d     = 1'b0;
      end
    end
  end

  always_comb begin
    any_op = 1'b0;
    for (int i = 0; i < NumOps; i++) begin
      if (job.ops[i].kind != OP_NONE) any_op = 1'b1;
    end
  end

  // A held lead with nothing due yields no job
  assign push_o = accept && any_op;
  assign job_o  = job;

  assign status_o.string_open  = open_q;
  assign status_o.lead_pending = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      pend_q <= 1'b0;
      held_q <= '0;
    end else if (accept) begin
      open_q <= open_d;
      pend_q <= pend_d;
      held_q <= held_d;
    end
  end

endmodule

/* rtl/jse_queue.sv */
// ----------------------------------------------------------------------------
// jse_queue: short job queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module jse_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     push_ready_o,
  input  jse_pkg::job_t            push_job_i,
  input  logic                     pop_i,
  output logic                     pop_valid_o,
  output jse_pkg::job_t            pop_job_o,
  output logic [jse_pkg::QCntW-1:0] count_o
);
  import jse_pkg::*;

  job_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != QCntW'(QDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign count_o      = count_q;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_job_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop)      count_q <= count_q + QCntW'(1);
      else if (!do_push && do_pop) count_q <= count_q - QCntW'(1);
    end
  end

endmodule

/* rtl/jse_back.sv */
// ----------------------------------------------------------------------------
// jse_back: output side of the JSON string escaper
// Walks the operations of one job, one unit per cycle, into an output
// register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  jse_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [jse_pkg::UnitW-1:0] out_unit_o,
  output logic                      out_last_o
);
  import jse_pkg::*;

  job_t             cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [SubW-1:0]  sub_q, sub_d;
  logic             out_valid_q, out_valid_d;
  logic [UnitW-1:0] out_unit_q, out_unit_d;
  logic             out_last_q, out_last_d;

  op_t              op;
  logic [UnitW-1:0] unit;
  logic             load_out, emit, op_end, job_end, take;
  logic [IdxW:0]    next_hit, first_hit;

  assign load_out  = !out_valid_q || out_ready_i;
  assign emit      = cur_valid_q && load_out;
  assign op        = cur_q.ops[idx_q];
  assign op_end    = sub_q == op_len(op.kind) - SubW'(1);
  assign next_hit  = find_op(cur_q, {1'b0, idx_q} + (IdxW+1)'(1));
  assign job_end   = op_end && !next_hit[IdxW];
  assign first_hit = find_op(job_i, '0);
  assign take      = job_valid_i && (!cur_valid_q || (emit && job_end));
  assign pop_o     = take;

  // Unit of the current step
  always_comb begin
    unit = op.value;
    if (op.kind == OP_HEX || op.kind == OP_ESC2) begin
      case (sub_q)
        SubW'(0): unit = ChBslash;
        SubW'(1): unit = (op.kind == OP_HEX) ? ChU : op.value;
        SubW'(2): unit = hex_digit(op.value[15:12]);
        SubW'(3): unit = hex_digit(op.value[11:8]);
        SubW'(4): unit = hex_digit(op.value[7:4]);
        default:  unit = hex_digit(op.value[3:0]);
      endcase
    end
  end

  // Sequencing of operations and steps
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    out_unit_d  = out_unit_q;
    out_last_d  = out_last_q;
    if (load_out) begin
      out_valid_d = emit;
      out_unit_d  = unit;
      out_last_d  = job_end;
    end
    if (emit) begin
      if (!op_end) begin
        sub_d = sub_q + SubW'(1);
      end else if (next_hit[IdxW]) begin
        idx_d = next_hit[IdxW-1:0];
        sub_d = '0;
      end else begin
        cur_valid_d = 1'b0;
      end
    end
    if (take) begin
      cur_d       = job_i;
      cur_valid_d = 1'b1;
      idx_d       = first_hit[IdxW-1:0];
      sub_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_unit_q <= out_unit_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_unit_o  = out_unit_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/json_string_escaper.sv */
// ----------------------------------------------------------------------------
// json_string_escaper: JSON quoting and escaping of a UTF-16 string stream
// Input items carry one code unit (tdata) or an end-of-string mark (tuser).
// Output items are UTF-16 units of the quoted string; tlast marks the final
// unit caused by one input item. An input item may cause zero to twelve
// output units: a held leading surrogate causes none, a \u escape six.
// The front end accepts one item per cycle while the two-entry job queue
// has room; the back end emits one unit per cycle, so an item causing N
// units occupies the back end until all N are out, and the queue then fills
// and drops s_axis_tready_o. An accepted item passes the queue, the job
// register and the output register before its first output unit appears.
// With the receiver ready, single-unit items pass at one item per cycle.
// Reset clears the queue, closes any string and drops a held surrogate.
// When the receiver stalls, the output register holds its unit, the back
// end pauses and the front end keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module json_string_escaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tuser_i,   // [0] action (1 = end of string)
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] out_unit
  output logic        m_axis_tlast_o    // last_of_run
);
  import jse_pkg::*;

  logic             push, push_ready, pop, pop_valid;
  job_t             push_job, pop_job;
  logic [QCntW-1:0] q_count;
  front_status_t    front_st;

  jse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_unit_i    (s_axis_tdata_i),
    .in_end_i     (s_axis_tuser_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .job_o        (push_job),
    .status_o     (front_st)
  );

  jse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .count_o      (q_count)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_unit_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // Queue fill never passes its depth
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QDepth))
    else $error("job queue overfilled");

  // No job is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> q_count != QCntW'(QDepth))
    else $error("push into full job queue");

  // An end item closes the string and drops any held lead
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i)
      |=> (!front_st.string_open && !front_st.lead_pending))
    else $error("string left open after end item");

  // A held lead always belongs to an open string
  a_lead_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.lead_pending |-> front_st.string_open)
    else $error("lead surrogate held outside a string");

endmodule
